// File: hw/rtl/sector_page_cache_lru_lookup_macros.svh
// ----------------------------------------------------------------------------
// sector page cache assertion macros
// shared property forms for the lookup engine checks
// ----------------------------------------------------------------------------
`ifndef SECTOR_PAGE_CACHE_LRU_LOOKUP_MACROS_SVH
`define SECTOR_PAGE_CACHE_LRU_LOOKUP_MACROS_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// sector page cache package
// shared widths, codes and structs of the lookup engine
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

   localparam int SECTOR_W = 32;
   localparam int LEN_W    = 9;
   localparam int STAMP_W  = 32;
   localparam int OFS_W    = 8;

   localparam logic [LEN_W-1:0]   SPP_RESET  = 9'd16;
   localparam logic [LEN_W-1:0]   LEN_MAX    = 9'd256;
   localparam logic [LEN_W-1:0]   LEN_MIN    = 9'd1;
   localparam logic [STAMP_W-1:0] STAMP_MAX  = 32'hFFFF_FFFF;
   localparam logic               SLOT_EMPTY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_FILL,
      UPD_CLEAR
   } upd_op_type;

   typedef struct packed {
      upd_op_type          op;
      logic [SECTOR_W-1:0] base;
      logic [LEN_W-1:0]    len;
      logic [STAMP_W-1:0]  stamp;
   } upd_type;

   typedef struct packed {
      logic hit;
      logic got_free;
   } scan_flags_type;

endpackage

`default_nettype wire

// File: hw/rtl/spc_rem_div.sv
// ----------------------------------------------------------------------------
// sector page cache remainder unit
// restoring division of the sector by the page length, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module spc_rem_div
   import spc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [SECTOR_W-1:0] dividend,
   input  wire logic [LEN_W-1:0]    divisor,
   output logic      [OFS_W-1:0]    remainder
);

   localparam int STEP_W = $clog2(SECTOR_W + 1);
   localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(SECTOR_W);

   logic [SECTOR_W-1:0] dvd_ff, dvd_in;
   logic [LEN_W-1:0]    dvs_ff, dvs_in;
   logic [OFS_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [LEN_W-1:0]    trial;
   logic [LEN_W-1:0]    diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[SECTOR_W-1]};
      diff    = trial - dvs_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         step_in = DIV_STEPS;
      end else if (step_ff != '0) begin
         dvd_in  = {dvd_ff[SECTOR_W-2:0], 1'b0};
         rem_in  = (trial >= dvs_ff) ? diff[OFS_W-1:0] : trial[OFS_W-1:0];
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: hw/rtl/spc_cell.sv
// ----------------------------------------------------------------------------
// sector page cache entry cell
// one cache entry plus its stage of the hit and victim scan chain
// ----------------------------------------------------------------------------
`default_nettype none

module spc_cell
   import spc_pkg::*;
#(
   parameter int IDX_W = 3,
   parameter int IDX   = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [SECTOR_W-1:0]  sector,
   input  wire upd_type              upd,
   input  wire logic [IDX_W-1:0]     upd_idx,
   input  wire scan_flags_type       flags_prev,
   input  wire logic [IDX_W-1:0]     idx_prev,
   input  wire logic [SECTOR_W-1:0]  base_prev,
   input  wire logic [STAMP_W-1:0]   oldest_prev,
   output scan_flags_type            flags_next,
   output logic      [IDX_W-1:0]     idx_next,
   output logic      [SECTOR_W-1:0]  base_next,
   output logic      [STAMP_W-1:0]   oldest_next
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic [SECTOR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                free_ff, free_in;
   logic [STAMP_W-1:0]  last_ff, last_in;

   scan_flags_type      flags_ff, flags_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SECTOR_W-1:0] hbase_ff, hbase_in;
   logic [STAMP_W-1:0]  oldest_ff, oldest_in;

   logic [SECTOR_W:0]   page_end;
   logic                match;
   logic                sel;

   // entry update
   always_comb begin
      sel     = (upd_idx == MY_IDX);
      base_in = base_ff;
      len_in  = len_ff;
      free_in = free_ff;
      last_in = last_ff;
      unique case (upd.op)
         UPD_NONE: begin
         end
         UPD_TOUCH: begin
            if (sel) begin
               last_in = upd.stamp;
            end
         end
         UPD_FILL: begin
            if (sel) begin
               base_in = upd.base;
               len_in  = upd.len;
               free_in = ~SLOT_EMPTY;
               last_in = upd.stamp;
            end
         end
         UPD_CLEAR: begin
            base_in = '0;
            len_in  = '0;
            free_in = SLOT_EMPTY;
            last_in = '0;
         end
         default: begin
         end
      endcase
   end

   // scan stage
   always_comb begin
      page_end  = {1'b0, base_ff} + {{(SECTOR_W + 1 - LEN_W){1'b0}}, len_ff};
      match     = (free_ff != SLOT_EMPTY) && (sector >= base_ff) &&
                  ({1'b0, sector} < page_end);
      flags_in  = flags_prev;
      idx_in    = idx_prev;
      hbase_in  = base_prev;
      oldest_in = oldest_prev;
      priority if (flags_prev.hit) begin
      end else if (match) begin
         flags_in.hit = 1'b1;
         idx_in       = MY_IDX;
         hbase_in     = base_ff;
      end else if (!flags_prev.got_free &&
                   (free_ff == SLOT_EMPTY || last_ff < oldest_prev)) begin
         flags_in.got_free = (free_ff == SLOT_EMPTY);
         idx_in            = MY_IDX;
         oldest_in         = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      hbase_ff  <= hbase_in;
      oldest_ff <= oldest_in;
      if (reset) begin
         base_ff  <= '0;
         len_ff   <= '0;
         free_ff  <= SLOT_EMPTY;
         last_ff  <= '0;
         flags_ff <= '0;
      end else begin
         base_ff  <= base_in;
         len_ff   <= len_in;
         free_ff  <= free_in;
         last_ff  <= last_in;
         flags_ff <= flags_in;
      end
   end

   assign flags_next  = flags_ff;
   assign idx_next    = idx_ff;
   assign base_next   = hbase_ff;
   assign oldest_next = oldest_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sector_page_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// sector page cache lru lookup
// tag and replacement engine of a fully associative disk-sector page cache
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall): one beat is a lookup (req_func 0)
//   or a clear of all entries (req_func 1). rsp channel (rsp_valid /
//   rsp_stall): one beat per request with hit, entry index, page base,
//   offset in page and fill flag. csr_wr_en / csr_wr_data set the page
//   length in sectors; write only while the block is idle.
//   in the scan the sector is divided by the page length one bit per
//   cycle while the request walks the row of entry cells one cell per
//   cycle. the result register loads in ST_FINISH after the scan, then
//   the block returns to idle; a clear goes straight to ST_FINISH.
//   req_stall is high while a request is in work. the result register is
//   separate, so a new request is taken while a result waits; if rsp_stall
//   holds the old result, the finished request waits for it to drain.
//   reset frees every entry, zeroes the use clock, sets 16 sectors per
//   page and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_page_cache_lru_lookup
   import spc_pkg::*;
#(
   parameter int PAGES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_func,
   input  wire logic [SECTOR_W-1:0] req_sector,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_hit,
   output logic      [2:0]          rsp_entry_index,
   output logic      [SECTOR_W-1:0] rsp_page_base,
   output logic      [OFS_W-1:0]    rsp_sector_in_page,
   output logic                     rsp_fill_needed,
   input  wire logic                csr_wr_en,
   input  wire logic [LEN_W-1:0]    csr_wr_data
);

   localparam int IDX_W       = $clog2(PAGES);
   localparam int SCAN_CYCLES = (PAGES > SECTOR_W) ? PAGES : SECTOR_W;
   localparam int CNT_W       = $clog2(SCAN_CYCLES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCAN_CYCLES - 1);

   state_type state_ff, state_in;

   logic [LEN_W-1:0]    spp_ff, spp_in;
   logic                func_ff, func_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STAMP_W-1:0]  use_clock_ff, use_clock_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SECTOR_W-1:0] pbase_ff, pbase_in;
   logic [OFS_W-1:0]    ofs_ff, ofs_in;
   logic                fill_ff, fill_in;

   logic                accept;
   logic                load;
   logic                look_load;
   logic                miss_load;
   logic [LEN_W-1:0]    len_clamped;
   logic [OFS_W-1:0]    rem;
   logic [SECTOR_W-1:0] miss_base;
   logic [SECTOR_W-1:0] hit_ofs;
   logic [STAMP_W-1:0]  stamp;
   logic [IDX_W+2:0]    idx_ext;
   upd_type             upd;

   scan_flags_type      chain_flags  [PAGES+1];
   logic [IDX_W-1:0]    chain_idx    [PAGES+1];
   logic [SECTOR_W-1:0] chain_base   [PAGES+1];
   logic [STAMP_W-1:0]  chain_oldest [PAGES+1];

   assign accept = req_valid && !req_stall;

   always_comb begin
      priority if (spp_ff == '0) begin
         len_clamped = LEN_MIN;
      end else if (spp_ff > LEN_MAX) begin
         len_clamped = LEN_MAX;
      end else begin
         len_clamped = spp_ff;
      end
   end

   spc_rem_div u_rem_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_sector),
      .divisor   (len_clamped),
      .remainder (rem)
   );

   assign chain_flags[0]  = '0;
   assign chain_idx[0]    = '0;
   assign chain_base[0]   = '0;
   assign chain_oldest[0] = STAMP_MAX;

   for (genvar g = 0; g < PAGES; g++) begin : g_entry
      spc_cell #(
         .IDX_W (IDX_W),
         .IDX   (g)
      ) u_entry (
         .clock       (clock),
         .reset       (reset),
         .sector      (sector_ff),
         .upd         (upd),
         .upd_idx     (chain_idx[PAGES]),
         .flags_prev  (chain_flags[g]),
         .idx_prev    (chain_idx[g]),
         .base_prev   (chain_base[g]),
         .oldest_prev (chain_oldest[g]),
         .flags_next  (chain_flags[g+1]),
         .idx_next    (chain_idx[g+1]),
         .base_next   (chain_base[g+1]),
         .oldest_next (chain_oldest[g+1])
      );
   end

   assign stamp     = use_clock_ff + 1'b1;
   assign miss_base = sector_ff - {{(SECTOR_W - OFS_W){1'b0}}, rem};
   assign hit_ofs   = sector_ff - chain_base[PAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      load         = 1'b0;
      func_in      = func_ff;
      sector_in    = sector_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      upd.op       = UPD_NONE;
      upd.base     = miss_base;
      upd.len      = len_ff;
      upd.stamp    = stamp;
      use_clock_in = use_clock_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in   = req_func;
               sector_in = req_sector;
               len_in    = len_clamped;
               cnt_in    = '0;
               state_in  = req_func ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (func_ff) begin
                  upd.op = UPD_CLEAR;
               end else begin
                  upd.op       = chain_flags[PAGES].hit ? UPD_TOUCH : UPD_FILL;
                  use_clock_in = stamp;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      spp_in       = csr_wr_en ? csr_wr_data : spp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      pbase_in     = pbase_ff;
      ofs_in       = ofs_ff;
      fill_in      = fill_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (func_ff) begin
            hit_in   = 1'b0;
            idx_in   = '0;
            pbase_in = '0;
            ofs_in   = '0;
            fill_in  = 1'b0;
         end else if (chain_flags[PAGES].hit) begin
            hit_in   = 1'b1;
            idx_in   = chain_idx[PAGES];
            pbase_in = chain_base[PAGES];
            ofs_in   = hit_ofs[OFS_W-1:0];
            fill_in  = 1'b0;
         end else begin
            hit_in   = 1'b0;
            idx_in   = chain_idx[PAGES];
            pbase_in = miss_base;
            ofs_in   = rem;
            fill_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      sector_ff <= sector_in;
      len_ff    <= len_in;
      cnt_ff    <= cnt_in;
      hit_ff    <= hit_in;
      idx_ff    <= idx_in;
      pbase_ff  <= pbase_in;
      ofs_ff    <= ofs_in;
      fill_ff   <= fill_in;
      if (reset) begin
         spp_ff       <= SPP_RESET;
         use_clock_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spp_ff       <= spp_in;
         use_clock_ff <= use_clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign idx_ext            = {3'b000, idx_ff};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_entry_index    = idx_ext[2:0];
   assign rsp_page_base      = pbase_ff;
   assign rsp_sector_in_page = ofs_ff;
   assign rsp_fill_needed    = fill_ff;

   assign look_load = load && !func_ff;
   assign miss_load = look_load && !chain_flags[PAGES].hit;

`include "sector_page_cache_lru_lookup_macros.svh"

   `SPC_ASSERT_NOW(a_hit_fill_excl, rsp_valid_ff, !(hit_ff && fill_ff), "hit and fill both set")
   `SPC_ASSERT_NOW(a_rem_in_page, miss_load, (rem < len_ff), "remainder not below page length")
   `SPC_ASSERT_NEXT(a_clock_step, look_load, (use_clock_ff == $past(stamp)), "use clock stalled")

endmodule

`default_nettype wire
